[src/utcl_pkg.sv]
// ----------------------------------------------------------------------------
// utcl_pkg
// Shared types, constants and the month length function for the UTC to local
// date and time converter.
// ----------------------------------------------------------------------------
package utcl_pkg;

  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 7;
  localparam int ZONE_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAYLIGHT_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWELVE_HOUR     = 2'd2;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd1;

  localparam logic [HOUR_W-1:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [HOUR_W-1:0]  HALF_DAY      = 5'd12;
  localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_LAST     = 7'd99;
  localparam logic [YEAR_W-1:0]  YEAR_SPAN     = 7'd100;

  localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [HOUR_W-1:0]  utc_hour;
    logic [DAY_W-1:0]   utc_day;
    logic [MONTH_W-1:0] utc_month;
    logic [YEAR_W-1:0]  utc_year;
  } in_item_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  local_hour;
    logic [DAY_W-1:0]   local_day;
    logic [MONTH_W-1:0] local_month;
    logic [YEAR_W-1:0]  local_year;
    logic               pm_flag;
  } out_item_t;

  typedef struct packed {
    logic signed [ZONE_W-1:0] zone_offset_hours;
    logic                     daylight_offset_hours;
    logic                     twelve_hour_mode;
  } cfg_t;

  // Length of a month; months past December count as December.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    if (month == MONTH_FEB && leap) begin
      len = LEAP_FEB_DAYS;
    end else if (month > MONTH_DEC) begin
      len = MONTH_LEN[12];
    end else begin
      len = MONTH_LEN[month];
    end
    return len;
  endfunction

endpackage

[src/utcl_cfg.sv]
// ----------------------------------------------------------------------------
// utcl_cfg
// Configuration registers: time-zone offset, daylight offset and 12-hour mode.
// ----------------------------------------------------------------------------
module utcl_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [utcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [utcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output utcl_pkg::cfg_t                    cfg
);

  utcl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_offset_hours     <= utcl_pkg::ZONE_RESET;
      cfg_r.daylight_offset_hours <= 1'b0;
      cfg_r.twelve_hour_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        utcl_pkg::REG_ZONE_OFFSET: begin
          cfg_r.zone_offset_hours <= cfg_wdata;
        end
        utcl_pkg::REG_DAYLIGHT_OFFSET: begin
          cfg_r.daylight_offset_hours <= cfg_wdata[0];
        end
        utcl_pkg::REG_TWELVE_HOUR: begin
          cfg_r.twelve_hour_mode <= cfg_wdata[0];
        end
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/utcl_conv.sv]
// ----------------------------------------------------------------------------
// utcl_conv
// Combinational conversion of one UTC reading into local hour and date.
// ----------------------------------------------------------------------------
module utcl_conv (
  input  utcl_pkg::in_item_t  in_item,
  input  utcl_pkg::cfg_t      cfg,
  output utcl_pkg::out_item_t out_item
);

  logic signed [6:0]              hour_sum;
  logic [utcl_pkg::HOUR_W-1:0]    hour_wrap;
  logic [utcl_pkg::HOUR_W-1:0]    hour_out;
  logic [utcl_pkg::DAY_W-1:0]     day_n;
  logic [utcl_pkg::MONTH_W-1:0]   month_n;
  logic [utcl_pkg::MONTH_W-1:0]   month_prev;
  logic [utcl_pkg::YEAR_W-1:0]    year_n;
  logic                           leap;
  logic [utcl_pkg::DAY_W-1:0]     len_cur;
  logic [utcl_pkg::DAY_W-1:0]     len_prev;
  logic [utcl_pkg::DAY_W-1:0]     day_out;
  logic [utcl_pkg::MONTH_W-1:0]   month_out;
  logic [utcl_pkg::YEAR_W-1:0]    year_out;
  logic                           pm;

  always_comb begin
    // Hour plus offsets lies in -16..47.
    hour_sum = $signed({2'b00, in_item.utc_hour})
             + $signed({{2{cfg.zone_offset_hours[utcl_pkg::ZONE_W-1]}},
                        cfg.zone_offset_hours})
             + $signed({6'b000000, cfg.daylight_offset_hours});

    // Clamp a zero day and an out-of-range month, and fold the year into 0..99.
    day_n   = (in_item.utc_day == '0) ? 5'd1 : in_item.utc_day;
    month_n = (in_item.utc_month == '0) ? utcl_pkg::MONTH_JAN :
              ((in_item.utc_month > utcl_pkg::MONTH_DEC) ? utcl_pkg::MONTH_DEC
                                                         : in_item.utc_month);
    year_n  = (in_item.utc_year >= utcl_pkg::YEAR_SPAN) ?
              in_item.utc_year - utcl_pkg::YEAR_SPAN : in_item.utc_year;
    leap    = (year_n[1:0] == 2'b00);

    month_prev = (month_n == utcl_pkg::MONTH_JAN) ? utcl_pkg::MONTH_DEC
                                                  : month_n - 4'd1;
    len_cur  = utcl_pkg::days_in(month_n, leap);
    len_prev = utcl_pkg::days_in(month_prev, leap);

    hour_wrap = hour_sum[utcl_pkg::HOUR_W-1:0];
    day_out   = day_n;
    month_out = month_n;
    year_out  = year_n;

    if (hour_sum < 0) begin
      hour_wrap = 5'(hour_sum + 7'sd24);
      if (day_n == 5'd1) begin
        // Borrow into the previous month.
        month_out = month_prev;
        day_out   = len_prev;
        if (month_n == utcl_pkg::MONTH_JAN) begin
          year_out = (year_n == '0) ? utcl_pkg::YEAR_LAST : year_n - 7'd1;
        end
      end else begin
        day_out = day_n - 5'd1;
      end
    end else if (hour_sum >= 7'sd24) begin
      hour_wrap = 5'(hour_sum - 7'sd24);
      if (day_n >= len_cur) begin
        // Carry into the next month, also from a day past the month end.
        day_out = 5'd1;
        if (month_n == utcl_pkg::MONTH_DEC) begin
          month_out = utcl_pkg::MONTH_JAN;
          year_out  = (year_n == utcl_pkg::YEAR_LAST) ? '0 : year_n + 7'd1;
        end else begin
          month_out = month_n + 4'd1;
        end
      end else begin
        day_out = day_n + 5'd1;
      end
    end

    pm       = 1'b0;
    hour_out = hour_wrap;
    if (cfg.twelve_hour_mode) begin
      pm       = (hour_wrap >= utcl_pkg::HALF_DAY);
      hour_out = pm ? hour_wrap - utcl_pkg::HALF_DAY : hour_wrap;
      if (hour_out == '0) begin
        hour_out = utcl_pkg::HALF_DAY;
      end
    end

    out_item.local_hour  = hour_out;
    out_item.local_day   = day_out;
    out_item.local_month = month_out;
    out_item.local_year  = year_out;
    out_item.pm_flag     = pm;
  end

endmodule

[src/utc_to_local_date_time.sv]
// ----------------------------------------------------------------------------
// utc_to_local_date_time
// Converts a UTC hour and date from a real-time clock into local time.
// ----------------------------------------------------------------------------
// The block takes one UTC reading (hour, day, month, two-digit year) per item
// and returns one local reading per item. It adds the signed time-zone offset
// and the daylight-saving hour, keeps the hour in 0..23 and moves the date by
// one day where the hour wraps, with month lengths from a fixed table and a
// 29-day February in years divisible by four; the year wraps modulo 100. In
// 12-hour mode the hour runs 1..12 and pm_flag marks afternoon hours. An item
// passes an input register and then a result register, and its result is
// offered on out_valid once it has reached the result register. A new item is
// accepted in every cycle; the only thing that holds the input back is a
// stalled output with both registers full, in which case in_stall follows
// out_stall in the same cycle.
// Configuration writes take effect at once and should be made while no item
// is in flight.
// ----------------------------------------------------------------------------
module utc_to_local_date_time (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [utcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [utcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input items.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  utcl_pkg::in_item_t              in_data,
  // Result items.
  output logic                            out_valid,
  input  logic                            out_stall,
  output utcl_pkg::out_item_t             out_data
);

  utcl_pkg::cfg_t      cfg;
  utcl_pkg::in_item_t  in_item_r;
  utcl_pkg::out_item_t conv_item;
  utcl_pkg::out_item_t out_item_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                out_load;
  logic                in_load;

  utcl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  utcl_conv u_conv (
    .in_item  (in_item_r),
    .cfg      (cfg),
    .out_item (conv_item)
  );

  // The result register can take a new item when it is empty or being read.
  assign out_load = !out_valid_r || !out_stall;
  // The input register can take an item when it is empty or moving forward.
  assign in_stall = in_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item_r <= in_data;
    end
    if (out_load && in_valid_r) begin
      out_item_r <= conv_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
